/* src/fwtm_pkg.sv */
package fwtm_pkg;

    // Queue geometry.
    localparam int QUEUE_DEPTH = 16;
    localparam int HANDLE_BITS = 16;

    // Fixed field widths of the item ports.
    localparam int HANDLE_W = 16;
    localparam int TAG_W    = 3;
    localparam int POS_W    = 5;

    // Stored handle width: the port carries 16 bits, the queue keeps HANDLE_BITS of them.
    localparam int STORE_W = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        FN_ENQ,
        FN_DEQ,
        FN_POS,
        FN_TYPE
    } t_func;

    typedef enum logic [1:0] {
        ST_OK,
        ST_EMPTY,
        ST_FULL,
        ST_NOTFOUND
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_SCAN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [STORE_W-1:0] handle;
    } t_entry;

endpackage

/* src/fwtm_if.sv */
interface fwtm_in_if;
    logic                                valid;
    logic                                ready;
    fwtm_pkg::t_func                     func;
    logic [fwtm_pkg::HANDLE_W-1:0]       entry_handle;
    logic [fwtm_pkg::TAG_W-1:0]          type_tag;

    modport source (output valid, output func, output entry_handle, output type_tag,
                    input ready);
    modport sink   (input valid, input func, input entry_handle, input type_tag,
                    output ready);
endinterface

interface fwtm_out_if;
    logic                                valid;
    logic                                ready;
    fwtm_pkg::t_status                   status;
    logic [fwtm_pkg::HANDLE_W-1:0]       handle_out;
    logic [fwtm_pkg::POS_W-1:0]          position;
    logic                                is_empty;

    modport source (output valid, output status, output handle_out, output position,
                    output is_empty, input ready);
    modport sink   (input valid, input status, input handle_out, input position,
                    input is_empty, output ready);
endinterface

/* src/fifo_with_type_match_search.sv */
// Bounded FIFO of 16-bit handles, each stored with a 3-bit type tag, plus two
// associative searches. Each input item (enqueue, dequeue, position of a handle,
// oldest entry of a type) gives exactly one result item, which carries a status,
// the handle removed or found, the 1-based position found, and whether the queue
// is empty after the operation. Entries live in one synchronous memory of
// QUEUE_DEPTH words with a registered read port, and the block works on one
// item at a time. An enqueue, or any operation on an empty queue, goes from
// acceptance straight to the response state; a dequeue first passes through
// the dequeue state, which takes the head entry from the read port. A search
// reads one entry per cycle starting at the head until the first hit, and
// examines at most the occupancy, 16 entries when full. The single memory
// read port sets the search rate. A new item is accepted while the previous
// result still waits in the output register; a result that cannot enter the
// output register holds the block until the receiver takes the one ahead of
// it. No reset sweep is needed, since only occupied entries are ever read.
module fifo_with_type_match_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fwtm_in_if.sink     i_in,
    fwtm_out_if.source  o_out
);

    localparam int PTR_W   = fwtm_pkg::PTR_W;
    localparam int CNT_W   = fwtm_pkg::CNT_W;
    localparam int STORE_W = fwtm_pkg::STORE_W;

    // Entry storage and its registered read port.
    fwtm_pkg::t_entry r_mem [fwtm_pkg::QUEUE_DEPTH];
    fwtm_pkg::t_entry r_rd_data;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    fwtm_pkg::t_entry wr_data;

    // Control state.
    fwtm_pkg::t_state r_state, n_state;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_occ, n_occ;

    // The item under work.
    fwtm_pkg::t_func             r_func, n_func;
    logic [STORE_W-1:0]          r_key, n_key;
    logic [fwtm_pkg::TAG_W-1:0]  r_tag, n_tag;
    logic [PTR_W-1:0]            r_slot, n_slot;
    logic [CNT_W-1:0]            r_idx, n_idx;

    // Result waiting to move into the output register.
    fwtm_pkg::t_status  r_res_status, n_res_status;
    logic [STORE_W-1:0] r_res_handle, n_res_handle;
    logic [CNT_W-1:0]   r_res_pos, n_res_pos;

    // Output register.
    logic                            r_out_valid, n_out_valid;
    fwtm_pkg::t_status               r_out_status, n_out_status;
    logic [fwtm_pkg::HANDLE_W-1:0]   r_out_handle, n_out_handle;
    logic [fwtm_pkg::POS_W-1:0]      r_out_pos, n_out_pos;
    logic                            r_out_empty, n_out_empty;

    logic             in_accept;
    logic             out_free;
    logic             is_full;
    logic             is_empty;
    logic             hit;
    logic             last;
    logic [CNT_W-1:0] idx_inc;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        n = (p == PTR_W'(fwtm_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return n;
    endfunction

    assign in_accept = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign is_full   = (r_occ == CNT_W'(fwtm_pkg::QUEUE_DEPTH));
    assign is_empty  = (r_occ == '0);
    assign idx_inc   = r_idx + CNT_W'(1);
    assign last      = (idx_inc == r_occ);
    assign hit       = (r_func == fwtm_pkg::FN_POS) ? (r_rd_data.handle == r_key)
                                                    : (r_rd_data.tag == r_tag);

    assign i_in.ready       = (r_state == fwtm_pkg::S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.handle_out = r_out_handle;
    assign o_out.position   = r_out_pos;
    assign o_out.is_empty   = r_out_empty;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            fwtm_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (i_in.func == fwtm_pkg::FN_ENQ || is_empty) begin
                        n_state = fwtm_pkg::S_RESP;
                    end else if (i_in.func == fwtm_pkg::FN_DEQ) begin
                        n_state = fwtm_pkg::S_DEQ;
                    end else begin
                        n_state = fwtm_pkg::S_SCAN;
                    end
                end
            end
            fwtm_pkg::S_DEQ: begin
                n_state = fwtm_pkg::S_RESP;
            end
            fwtm_pkg::S_SCAN: begin
                if (hit || last) begin
                    n_state = fwtm_pkg::S_RESP;
                end
            end
            fwtm_pkg::S_RESP: begin
                if (out_free) begin
                    n_state = fwtm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fwtm_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and output register.
    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_occ        = r_occ;
        n_func       = r_func;
        n_key        = r_key;
        n_tag        = r_tag;
        n_slot       = r_slot;
        n_idx        = r_idx;
        n_res_status = r_res_status;
        n_res_handle = r_res_handle;
        n_res_pos    = r_res_pos;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_handle = r_out_handle;
        n_out_pos    = r_out_pos;
        n_out_empty  = r_out_empty;
        rd_en        = 1'b0;
        rd_addr      = r_head;
        wr_en        = 1'b0;
        wr_addr      = r_tail;
        wr_data      = '{tag: i_in.type_tag, handle: i_in.entry_handle[STORE_W-1:0]};

        case (r_state)
            fwtm_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_func       = i_in.func;
                    n_key        = i_in.entry_handle[STORE_W-1:0];
                    n_tag        = i_in.type_tag;
                    n_res_handle = '0;
                    n_res_pos    = '0;
                    n_res_status = fwtm_pkg::ST_OK;
                    if (i_in.func == fwtm_pkg::FN_ENQ) begin
                        if (is_full) begin
                            n_res_status = fwtm_pkg::ST_FULL;
                        end else begin
                            wr_en  = 1'b1;
                            n_tail = next_ptr(r_tail);
                            n_occ  = r_occ + CNT_W'(1);
                        end
                    end else if (is_empty) begin
                        n_res_status = fwtm_pkg::ST_EMPTY;
                    end else begin
                        // Start reading at the head; dequeue and both searches begin there.
                        rd_en  = 1'b1;
                        n_slot = r_head;
                        n_idx  = '0;
                    end
                end
            end
            fwtm_pkg::S_DEQ: begin
                n_res_status = fwtm_pkg::ST_OK;
                n_res_handle = r_rd_data.handle;
                n_head       = next_ptr(r_head);
                n_occ        = r_occ - CNT_W'(1);
            end
            fwtm_pkg::S_SCAN: begin
                if (hit) begin
                    n_res_status = fwtm_pkg::ST_OK;
                    n_res_handle = r_rd_data.handle;
                    n_res_pos    = idx_inc;
                end else if (last) begin
                    n_res_status = fwtm_pkg::ST_NOTFOUND;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = next_ptr(r_slot);
                    n_slot  = next_ptr(r_slot);
                    n_idx   = idx_inc;
                end
            end
            fwtm_pkg::S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_handle = fwtm_pkg::HANDLE_W'(r_res_handle);
                    n_out_pos    = fwtm_pkg::POS_W'(r_res_pos);
                    n_out_empty  = is_empty;
                end
            end
            default: begin
                n_out_valid = r_out_valid && !o_out.ready;
            end
        endcase
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fwtm_pkg::S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_key        <= n_key;
        r_tag        <= n_tag;
        r_slot       <= n_slot;
        r_idx        <= n_idx;
        r_res_status <= n_res_status;
        r_res_handle <= n_res_handle;
        r_res_pos    <= n_res_pos;
        r_out_status <= n_out_status;
        r_out_handle <= n_out_handle;
        r_out_pos    <= n_out_pos;
        r_out_empty  <= n_out_empty;
    end

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(fwtm_pkg::QUEUE_DEPTH))
        else $error("occupancy exceeds queue depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ == '0) |-> (r_head == r_tail))
        else $error("empty queue with head and tail apart");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fwtm_pkg::S_SCAN) |-> (r_idx < r_occ))
        else $error("search ran past the occupied entries");

    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.func == fwtm_pkg::FN_ENQ && !is_full)
        |=> (r_occ == $past(r_occ) + CNT_W'(1)))
        else $error("enqueue did not add one entry");

    a_pos_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_pos != '0) |-> (r_out_status == fwtm_pkg::ST_OK))
        else $error("position reported without a match");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

// Self-checking bench for the handle queue with handle and type searches.
// A software image of the queue (two SystemVerilog queues, one for handles and
// one for tags) predicts every result when its input item is accepted, and the
// result checker pops those predictions in order. Both the sender and the
// receiver idle at random, and the receiver can be told to hold off for a long
// stretch so that the block backs up into its input.
module testbench;

    localparam int HANDLE_W    = fwtm_pkg::HANDLE_W;
    localparam int TAG_W       = fwtm_pkg::TAG_W;
    localparam int POS_W       = fwtm_pkg::POS_W;
    localparam int STORE_W     = fwtm_pkg::STORE_W;
    localparam int QUEUE_DEPTH = fwtm_pkg::QUEUE_DEPTH;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_ITEMS = 320;
    localparam int TAIL_CYCLES  = 40;

    // The queue keeps only STORE_W bits of each handle.
    localparam logic [HANDLE_W-1:0] HANDLE_MASK = HANDLE_W'((64'd1 << STORE_W) - 64'd1);

    typedef struct {
        fwtm_pkg::t_status   status;
        logic [HANDLE_W-1:0] handle;
        logic [POS_W-1:0]    position;
        logic                is_empty;
    } t_queue_result;

    logic i_clk;
    logic i_rst_n;

    fwtm_in_if  in_ch ();
    fwtm_out_if out_ch ();

    fifo_with_type_match_search dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Image of the queue contents, oldest entry at index 0.
    logic [HANDLE_W-1:0] queued_handles[$];
    logic [TAG_W-1:0]    queued_tags[$];

    // Results predicted for accepted items that have not come out yet.
    t_queue_result       pending_results[$];

    int error_count     = 0;
    int cycle_count     = 0;
    int src_idle_pct    = 0;
    int sink_stall_pct  = 0;
    int sink_stall_left = 0;
    bit sink_hold_req   = 1'b0;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Hard stop in case the block hangs or loses a handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("fifo_with_type_match_search test failed");
            $finish;
        end
    end

    // Applies one operation to the queue image and returns the result that
    // the block must produce for it. Searches scan from the oldest entry and
    // report the first hit with its 1-based place; they leave the queue alone.
    function automatic t_queue_result apply_queue_op(fwtm_pkg::t_func op,
                                                     logic [HANDLE_W-1:0] handle_in,
                                                     logic [TAG_W-1:0] tag_in);
        t_queue_result       res;
        logic [HANDLE_W-1:0] key;
        int                  idx;
        key          = handle_in & HANDLE_MASK;
        res.status   = fwtm_pkg::ST_OK;
        res.handle   = '0;
        res.position = '0;
        case (op)
            fwtm_pkg::FN_ENQ: begin
                if (queued_handles.size() >= QUEUE_DEPTH) begin
                    res.status = fwtm_pkg::ST_FULL;
                end else begin
                    queued_handles.push_back(key);
                    queued_tags.push_back(tag_in);
                end
            end
            fwtm_pkg::FN_DEQ: begin
                if (queued_handles.size() == 0) begin
                    res.status = fwtm_pkg::ST_EMPTY;
                end else begin
                    res.handle = queued_handles.pop_front();
                    void'(queued_tags.pop_front());
                end
            end
            default: begin
                if (queued_handles.size() == 0) begin
                    res.status = fwtm_pkg::ST_EMPTY;
                end else begin
                    res.status = fwtm_pkg::ST_NOTFOUND;
                    for (idx = 0; idx < queued_handles.size(); idx++) begin
                        if ((op == fwtm_pkg::FN_POS && queued_handles[idx] == key) ||
                            (op == fwtm_pkg::FN_TYPE && queued_tags[idx] == tag_in)) begin
                            res.status   = fwtm_pkg::ST_OK;
                            res.handle   = queued_handles[idx];
                            res.position = POS_W'(idx + 1);
                            break;
                        end
                    end
                end
            end
        endcase
        res.is_empty = (queued_handles.size() == 0);
        return res;
    endfunction

    // Idle lengths: mostly short, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(12, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // Offers one item until the block takes it, records the predicted result,
    // then maybe idles. With no idle, valid stays high for the next item; any
    // caller that stops sending lowers it through wait_results_drained.
    task automatic send_item(fwtm_pkg::t_func op, logic [HANDLE_W-1:0] handle_in,
                             logic [TAG_W-1:0] tag_in);
        int gap;
        @(negedge i_clk);
        in_ch.valid        <= 1'b1;
        in_ch.func         <= op;
        in_ch.entry_handle <= handle_in;
        in_ch.type_tag     <= tag_in;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        pending_results.push_back(apply_queue_op(op, handle_in, tag_in));
        gap = ($urandom_range(0, 99) < src_idle_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Stops offering and waits until every predicted result has come out.
    task automatic wait_results_drained();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Handles for enqueues and lookups. A small pool of values makes duplicate
    // handles common, so the position search must return the first of them.
    // Lookups mostly target a handle that is really in the queue.
    function automatic logic [HANDLE_W-1:0] choose_handle(fwtm_pkg::t_func op);
        int pick;
        pick = $urandom_range(0, 99);
        if (op == fwtm_pkg::FN_POS && queued_handles.size() != 0 && pick < 70) begin
            return queued_handles[$urandom_range(0, queued_handles.size() - 1)];
        end
        if (pick >= 75) begin
            return HANDLE_W'($urandom_range(0, 3)) << 14;
        end
        return HANDLE_W'($urandom);
    endfunction

    // One random item; enq_pct steers the queue toward full or toward empty.
    task automatic send_random_item(int enq_pct);
        fwtm_pkg::t_func op;
        int              pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            op = fwtm_pkg::t_func'($urandom_range(0, 3));
        end else if (pick < enq_pct) begin
            op = fwtm_pkg::FN_ENQ;
        end else begin
            case ($urandom_range(0, 3))
                0, 1: op = fwtm_pkg::FN_DEQ;
                2:    op = fwtm_pkg::FN_POS;
                default: op = fwtm_pkg::FN_TYPE;
            endcase
        end
        send_item(op, choose_handle(op), TAG_W'($urandom_range(0, 7)));
    endtask

    // Receiver: decides ready at each falling edge. A hold request from a test
    // blocks it for HOLD_CYCLES, counted here.
    initial begin : sink_driver
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (sink_stall_left > 0) begin
                sink_stall_left--;
                out_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 99) < sink_stall_pct) begin
                sink_stall_left = pick_gap() - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Every accepted result is compared with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_queue_result want;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, status %0h handle %0h",
                         $time, out_ch.status, out_ch.handle_out);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_ch.status !== want.status) begin
                    $display("%0t: status expected %0h actual %0h",
                             $time, want.status, out_ch.status);
                    error_count++;
                end
                if (out_ch.handle_out !== want.handle) begin
                    $display("%0t: handle_out expected %0h actual %0h",
                             $time, want.handle, out_ch.handle_out);
                    error_count++;
                end
                if (out_ch.position !== want.position) begin
                    $display("%0t: position expected %0d actual %0d",
                             $time, want.position, out_ch.position);
                    error_count++;
                end
                if (out_ch.is_empty !== want.is_empty) begin
                    $display("%0t: is_empty expected %0b actual %0b",
                             $time, want.is_empty, out_ch.is_empty);
                    error_count++;
                end
            end
        end
    end

    // Dequeue and both searches on a queue that was never written must say empty.
    task automatic test_empty_queue();
        send_item(fwtm_pkg::FN_DEQ, '0, '0);
        send_item(fwtm_pkg::FN_POS, '0, '0);
        send_item(fwtm_pkg::FN_POS, 16'hFFFF, 3'd7);
        send_item(fwtm_pkg::FN_TYPE, 16'h1234, 3'd7);
        wait_results_drained();
    endtask

    // A few entries with extreme handles and tags, then hits at the head and
    // at the tail, misses for both searches, a full drain and one dequeue too
    // many.
    task automatic test_basic_ops();
        send_item(fwtm_pkg::FN_ENQ, 16'h0000, 3'd0);
        send_item(fwtm_pkg::FN_ENQ, 16'hFFFF, 3'd7);
        send_item(fwtm_pkg::FN_ENQ, 16'hAAAA, 3'd5);
        send_item(fwtm_pkg::FN_ENQ, 16'h5555, 3'd2);
        send_item(fwtm_pkg::FN_POS, 16'h0000, 3'd4);
        send_item(fwtm_pkg::FN_POS, 16'h5555, 3'd0);
        send_item(fwtm_pkg::FN_POS, 16'h1234, 3'd0);
        send_item(fwtm_pkg::FN_TYPE, 16'h0000, 3'd7);
        send_item(fwtm_pkg::FN_TYPE, 16'hFFFF, 3'd3);
        send_item(fwtm_pkg::FN_TYPE, 16'h0000, 3'd0);
        repeat (5) send_item(fwtm_pkg::FN_DEQ, 16'hFFFF, 3'd7);
        wait_results_drained();
    endtask

    // Fills the queue, pushes once more into a full queue, finds the newest
    // entry at the last place, then drains past empty.
    task automatic test_full_queue();
        int n;
        for (n = 0; n < QUEUE_DEPTH; n++) begin
            send_item(fwtm_pkg::FN_ENQ, {(HANDLE_W - 4)'($urandom), 4'(n)},
                      TAG_W'($urandom_range(0, 7)));
        end
        send_item(fwtm_pkg::FN_ENQ, 16'hBEEF, 3'd1);
        send_item(fwtm_pkg::FN_POS, queued_handles[QUEUE_DEPTH - 1], 3'd0);
        send_item(fwtm_pkg::FN_TYPE, '0, queued_tags[QUEUE_DEPTH - 1]);
        repeat (QUEUE_DEPTH + 1) send_item(fwtm_pkg::FN_DEQ, '0, '0);
        wait_results_drained();
    endtask

    // The receiver stops for a long time while items keep coming, so the
    // result register fills and the block must hold off its input.
    task automatic test_output_backpressure();
        sink_hold_req = 1'b1;
        repeat (40) send_random_item(70);
        wait_results_drained();
    endtask

    // Long random run. The enqueue share alternates so the queue swings
    // between full and empty, idling changes every segment, and now and then
    // the sender waits until everything has come out.
    task automatic test_random_traffic();
        int n;
        int enq_pct;
        enq_pct = 80;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                enq_pct        = (enq_pct == 80) ? 20 : 80;
                src_idle_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
                sink_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
            end
            if (n % 100 == 99) begin
                wait_results_drained();
            end
            send_random_item(enq_pct);
        end
        wait_results_drained();
    endtask

    initial begin
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.func         = fwtm_pkg::FN_ENQ;
        in_ch.entry_handle = '0;
        in_ch.type_tag     = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cases run with steady handshakes first, then with idling.
        test_empty_queue();
        test_basic_ops();
        test_full_queue();
        src_idle_pct   = 30;
        sink_stall_pct = 30;
        test_full_queue();
        src_idle_pct   = 0;
        test_output_backpressure();
        test_random_traffic();

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("fifo_with_type_match_search test passed");
        end else begin
            $display("fifo_with_type_match_search test failed");
        end
        $finish;
    end

endmodule

/* fifo_with_type_match_search.f */
src/fwtm_pkg.sv
src/fwtm_if.sv
src/fifo_with_type_match_search.sv
tb/testbench.sv
